// File: rtl/assert_macros.svh
// Assertion macros shared by the sampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define CDT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define CDT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cdt_pkg.sv
// Types and constants for the CDT Gaussian sampler.
`default_nettype none

package cdt_pkg;

  // Field and register widths
  localparam int DATA_W    = 64;
  localparam int HW_W      = 6;
  localparam int IN_IDX_W  = 7;
  localparam int CFG_IDX_W = 1;

  // Priority encoder grouping
  localparam int GRP_W = 8;
  localparam int OFF_W = 3;

  typedef enum logic [0:0] {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS    = 1'b0,
    REG_HALF_WIDTH = 1'b1
  } cfg_reg_e;

endpackage

`default_nettype wire

// File: rtl/cdt_gaussian_sampler.sv
// CDT Gaussian sampler: table of CDF cells, compare, two-level priority encode, offset.
// Pipeline: 5 register stages (input, hit vector, group summaries, index, output).
// Throughput: one transaction per cycle while the output is not stalled; load transactions retire in the first stage.
// Table cells each own a 64-bit comparator, so every sample is compared against all entries in parallel.
// Reset clears pipeline valids, sets modulus to 1 and half_width to 0; table is unset.
`default_nettype none

module cdt_gaussian_sampler #(
  parameter int MAX_HALF_WIDTH = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [cdt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [cdt_pkg::DATA_W-1:0]       cfg_data_i,
  // input channel
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire cdt_pkg::cmd_e                    cmd_i,
  input  wire logic [cdt_pkg::IN_IDX_W-1:0]     entry_index_i,
  input  wire logic [cdt_pkg::DATA_W-1:0]       entry_value_i,
  input  wire logic [cdt_pkg::DATA_W-1:0]       random_word_i,
  // output channel
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic [cdt_pkg::DATA_W-1:0]       sample_value_o
);

  import cdt_pkg::*;

`include "assert_macros.svh"

  localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int NGRP  = (DEPTH + GRP_W - 1) / GRP_W;
  localparam int HPW   = NGRP * GRP_W;

  // Configuration registers
  logic [DATA_W-1:0] cfg_mod_q;
  logic [HW_W-1:0]   cfg_hw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mod_q <= DATA_W'(1);
      cfg_hw_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MODULUS:    cfg_mod_q <= cfg_data_i;
        REG_HALF_WIDTH: cfg_hw_q  <= cfg_data_i[HW_W-1:0];
        default:        ;
      endcase
    end
  end

  // Saturated half width and last usable table index
  logic [IDX_W-1:0] hw_sat;
  logic [IDX_W-1:0] tbl_lim;

  always_comb begin
    if (32'(cfg_hw_q) > 32'(MAX_HALF_WIDTH)) begin
      hw_sat = IDX_W'(MAX_HALF_WIDTH);
    end else begin
      hw_sat = IDX_W'(cfg_hw_q);
    end
    tbl_lim = IDX_W'({hw_sat, 1'b0});
  end

  // Stage handshake: each stage moves when it is empty or its successor moves; stage 1 also moves when it holds a load
  logic out_valid_q, s4_valid_q, s3_valid_q, s2_valid_q, s1_valid_q;
  cmd_e s1_cmd_q;
  logic out_ready, s4_ready, s3_ready, s2_ready, s1_ready;
  logic in_acc;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s4_ready   = !s4_valid_q || out_ready;
  assign s3_ready   = !s3_valid_q || s4_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || (s1_cmd_q == CMD_LOAD) || s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_acc     = in_valid_i && s1_ready;

  // Stage 1: input register
  logic [IN_IDX_W-1:0] s1_idx_q;
  logic [DATA_W-1:0]   s1_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_cmd_q   <= CMD_LOAD;
    end else if (s1_ready) begin
      s1_valid_q <= in_acc;
      s1_cmd_q   <= cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_idx_q  <= entry_index_i;
      s1_data_q <= (cmd_i == CMD_LOAD) ? entry_value_i : random_word_i;
    end
  end

  // CDF table cells; a load writes in stage 1 so later samples see it in order
  logic [DATA_W-1:0] tbl_q [DEPTH];
  logic              tbl_we;

  assign tbl_we = s1_valid_q && (s1_cmd_q == CMD_LOAD) && (32'(s1_idx_q) < 32'(DEPTH));

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_q[IDX_W'(s1_idx_q)] <= s1_data_q;
    end
  end

  // Per-cell compare against the random word, masked to the active table length
  logic [HPW-1:0] hits_d;
  logic [HPW-1:0] s2_hits_q;

  always_comb begin
    hits_d = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hits_d[i] = (IDX_W'(i) <= tbl_lim) && (tbl_q[i] >= s1_data_q);
    end
  end

  // Stage 2: hit vector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q && (s1_cmd_q == CMD_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready) begin
      s2_hits_q <= hits_d;
    end
  end

  // First hit inside each group of cells
  logic [NGRP-1:0]  grp_any_d;
  logic [OFF_W-1:0] grp_off_d [NGRP];
  logic [NGRP-1:0]  s3_any_q;
  logic [OFF_W-1:0] s3_off_q [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_d[g] = |s2_hits_q[g*GRP_W +: GRP_W];
      grp_off_d[g] = '0;
      for (int j = GRP_W - 1; j >= 0; j--) begin
        if (s2_hits_q[g*GRP_W + j]) begin
          grp_off_d[g] = OFF_W'(j);
        end
      end
    end
  end

  // Stage 3: group summaries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready) begin
      s3_any_q <= grp_any_d;
      s3_off_q <= grp_off_d;
    end
  end

  // First group with a hit gives the table index
  logic             found_d;
  logic [IDX_W-1:0] idx_d;
  logic             s4_found_q;
  logic [IDX_W-1:0] s4_idx_q;

  always_comb begin
    found_d = |s3_any_q;
    idx_d   = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (s3_any_q[g]) begin
        idx_d = IDX_W'(g * GRP_W) + IDX_W'(s3_off_q[g]);
      end
    end
  end

  // Stage 4: index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (s4_ready) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_ready) begin
      s4_found_q <= found_d;
      s4_idx_q   <= idx_d;
    end
  end

  // Center on zero, wrap negatives by the modulus; no hit gives zero
  logic [DATA_W-1:0] diff;
  logic [DATA_W-1:0] result_d;
  logic [DATA_W-1:0] sample_q;

  always_comb begin
    diff = DATA_W'(s4_idx_q) - DATA_W'(hw_sat);
    if (!s4_found_q) begin
      result_d = '0;
    end else if (s4_idx_q < hw_sat) begin
      result_d = cfg_mod_q + diff;
    end else begin
      result_d = diff;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      sample_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = sample_q;

  // Checks
  `CDT_ASSERT_IMP(a_idx_in_table, s4_valid_q && s4_found_q, s4_idx_q <= tbl_lim, "index past table")
  `CDT_ASSERT_IMP(a_free_flow, !out_stall_i, !in_stall_o, "input stalled while output drains")
  `CDT_ASSERT_NXT(a_out_from_s4, !out_valid_q && !s4_valid_q, !out_valid_q, "result without source")

endmodule

`default_nettype wire
